// ----- src/taeq_pkg.sv -----
// Shared types, widths and command codes for the timestamp age expiry queue.
package taeq_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int TIME_WIDTH  = 48;

    localparam int MODE_W    = 2;
    localparam int AMOUNT_W  = 32;
    localparam int REMOVED_W = 11;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (TIME_WIDTH > AMOUNT_W) ? TIME_WIDTH : AMOUNT_W;
    localparam int SUM_W = CMP_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_ADVANCE = 2'd1,
        MODE_EXPIRE  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [AMOUNT_W-1:0] amount;
    } in_t;

    typedef struct packed {
        logic [REMOVED_W-1:0] removed_count;
        logic                 dropped;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic do_insert;
        logic do_advance;
        logic rd_head;
        logic pop;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              empty;
        logic              aged;
    } status_t;

endpackage

// ----- src/taeq_ctrl.sv -----
// Command sequencer: accepts one transfer, runs insert, advance or the expire scan.
module taeq_ctrl
    import taeq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (mode_t'(status.mode))
                    MODE_INSERT: begin
                        cmd.do_insert = 1'b1;
                        state_next    = ST_DONE;
                    end
                    MODE_ADVANCE: begin
                        cmd.do_advance = 1'b1;
                        state_next     = ST_DONE;
                    end
                    MODE_EXPIRE: begin
                        state_next = ST_SCAN;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (status.empty) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP: begin
                // head stamp is in the read register now
                if (status.aged) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/taeq_dp.sv -----
// Datapath: stamp ring memory, pointers, occupancy, current time and result register.
module taeq_dp
    import taeq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  in_t     s_data,
    input  cmd_t    cmd,
    output status_t status,
    output out_t    m_data
);

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    logic [TIME_WIDTH-1:0] stamp_mem [QUEUE_DEPTH];

    in_t                   op_reg;
    logic [TIME_WIDTH-1:0] time_reg, time_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [OCC_W-1:0]      cnt_reg;
    logic                  drop_reg;
    logic [TIME_WIDTH-1:0] rd_data_reg;
    out_t                  out_reg;

    logic                  full;
    logic [TIME_WIDTH-1:0] age;
    logic [SUM_W-1:0]      sum;

    assign full = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign age  = time_reg - rd_data_reg;
    assign sum  = SUM_W'(time_reg) + SUM_W'(op_reg.amount);

    assign status.mode  = op_reg.mode;
    assign status.empty = (occ_reg == '0);
    assign status.aged  = (CMP_W'(age) >= CMP_W'(op_reg.amount));

    assign m_data = out_reg;

    always_comb begin
        time_next = time_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (cmd.do_advance) begin
            time_next = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_WIDTH-1:0];
        end
        if (cmd.do_insert && !full) begin
            tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            occ_next  = occ_reg + 1'b1;
        end
        if (cmd.pop) begin
            head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            occ_next  = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end else begin
            time_reg <= time_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_insert && !full) begin
            stamp_mem[tail_reg] <= time_reg;
        end
        if (cmd.rd_head) begin
            rd_data_reg <= stamp_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= s_data;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            if (cmd.pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.do_insert && full) begin
                drop_reg <= 1'b1;
            end
        end
        if (cmd.load_out) begin
            out_reg.removed_count <= REMOVED_W'(cnt_reg);
            out_reg.dropped       <= drop_reg;
        end
    end

endmodule

// ----- src/timestamp_age_expiry_queue.sv -----
// Top level of the timestamp age expiry queue: sequencer plus datapath.
// One command transfer is taken at a time and yields exactly one result transfer.
// Insert, advance and the unused mode go from input transfer straight through the
// execute state to the result; an expire scans the stamps from the head, each entry
// taking a registered head read and then an age compare, until the store is empty
// or the head stamp is younger than the threshold.
// A result still waiting on m_ready delays loading the next one. The stamp memory
// needs no clearing pass after reset.
// Input is accepted again in the cycle after the result is loaded, even while
// that result still waits on m_ready.
module timestamp_age_expiry_queue
    import taeq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t    cmd;
    status_t status;

    taeq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    taeq_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

// ----- src/taeq_checker.sv -----
// Port-level checks for the timestamp age expiry queue, bound to the top level.
module taeq_checker
    import taeq_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // one command in flight: no input transfer right after another
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a command is in flight");

    // a drop only comes from insert, which removes nothing
    a_drop_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dropped |-> m_data.removed_count == '0)
        else $error("dropped insert reports removed entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.removed_count) <= 32'(QUEUE_DEPTH))
        else $error("removed count beyond queue depth");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind timestamp_age_expiry_queue taeq_checker u_taeq_checker (.*);

// ----- sim/taeq_checker.sv -----
// Checker for the timestamp age expiry queue: tracks the stamp FIFO, predicts and compares.
module taeq_scoreboard
    import taeq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   mismatches,
    output int   outstanding,
    output int   cmd_total,
    output int   stamps_expired,
    output int   inserts_refused,
    output int   peak_fill,
    output logic hit_time_ceiling
);

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    logic [TIME_WIDTH-1:0] clock_now = '0;
    logic [TIME_WIDTH-1:0] stamp_fifo[$];
    out_t                  pending_results[$];

    int   fail_total    = 0;
    int   cmd_count     = 0;
    int   expired_count = 0;
    int   refused_count = 0;
    int   fill_peak     = 0;
    logic ceiling_seen  = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_total < 40) begin
            $display("%0t taeq_scoreboard: %s: got %0d, expected %0d", $time, what, got, want);
        end
        fail_total++;
    endtask

    // Applies one command to the tracked queue state and returns its result.
    function automatic out_t apply_command(input in_t cmd);
        out_t                  res;
        logic [TIME_WIDTH:0]   sum;
        logic [TIME_WIDTH:0]   step;
        logic [TIME_WIDTH-1:0] threshold;
        logic [TIME_WIDTH-1:0] age;
        int                    removed;
        logic                  done;
        res     = '0;
        removed = 0;
        case (cmd.mode)
            MODE_INSERT: begin
                if (stamp_fifo.size() >= QUEUE_DEPTH) begin
                    res.dropped = 1'b1;
                    refused_count++;
                end else begin
                    stamp_fifo.insert(stamp_fifo.size(), clock_now);
                end
                if (stamp_fifo.size() > fill_peak) begin
                    fill_peak = stamp_fifo.size();
                end
            end
            MODE_ADVANCE: begin
                step = (TIME_WIDTH+1)'(cmd.amount);
                sum  = {1'b0, clock_now} + step;
                // saturate at the top of the time range
                clock_now = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
                if (clock_now == TIME_MAX) begin
                    ceiling_seen = 1'b1;
                end
            end
            MODE_EXPIRE: begin
                threshold = TIME_WIDTH'(cmd.amount);
                done      = 1'b0;
                while (!done && stamp_fifo.size() > 0) begin
                    age = clock_now - stamp_fifo[0];
                    if (age < threshold) begin
                        done = 1'b1;
                    end else begin
                        stamp_fifo.delete(0);
                        removed++;
                    end
                end
                res.removed_count = REMOVED_W'(removed);
                expired_count += removed;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            clock_now = '0;
            stamp_fifo.delete();
            pending_results.delete();
        end else begin
            // a result can leave in the same cycle the next command transfers; check it first
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transfer with nothing pending, removed_count",
                                    int'(m_data.removed_count), 0);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (m_data.removed_count !== want.removed_count) begin
                        report_mismatch("removed_count", int'(m_data.removed_count),
                                        int'(want.removed_count));
                    end
                    if (m_data.dropped !== want.dropped) begin
                        report_mismatch("dropped", int'(m_data.dropped), int'(want.dropped));
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_results.insert(pending_results.size(), apply_command(s_data));
                cmd_count++;
            end
        end
        mismatches       <= fail_total;
        outstanding      <= pending_results.size();
        cmd_total        <= cmd_count;
        stamps_expired   <= expired_count;
        inserts_refused  <= refused_count;
        peak_fill        <= fill_peak;
        hit_time_ceiling <= ceiling_seen;
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the timestamp age expiry queue: clock, reset, stimulus and verdict.
module tb;
    import taeq_pkg::*;

    localparam logic [MODE_W-1:0]   MODE_SPARE       = 2'd3;
    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX       = '1;
    localparam int                  CYCLE_LIMIT      = 3_000_000;
    localparam int                  HOLD_CYCLES      = 400;
    localparam int                  RANDOM_PER_PHASE = 108;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;
    int   cycle_count    = 0;

    int   mismatches;
    int   outstanding;
    int   cmd_total;
    int   stamps_expired;
    int   inserts_refused;
    int   peak_fill;
    logic hit_time_ceiling;

    timestamp_age_expiry_queue u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    taeq_scoreboard u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .cmd_total        (cmd_total),
        .stamps_expired   (stamps_expired),
        .inserts_refused  (inserts_refused),
        .peak_fill        (peak_fill),
        .hit_time_ceiling (hit_time_ceiling)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side: random stalls plus a single long hold-off.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic in_t make_cmd(input logic [MODE_W-1:0] mode,
                                     input logic [AMOUNT_W-1:0] amount);
        in_t cmd;
        cmd.mode   = mode;
        cmd.amount = amount;
        return cmd;
    endfunction

    // Mostly small advances and thresholds so expires land part way into the queue.
    function automatic in_t random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            return make_cmd(MODE_INSERT, $urandom);
        end else if (pick < 68) begin
            return make_cmd(MODE_ADVANCE,
                            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 50));
        end else if (pick < 95) begin
            return make_cmd(MODE_EXPIRE,
                            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 150));
        end
        return make_cmd(MODE_SPARE, $urandom);
    endfunction

    // Holds valid until the transfer, then maybe goes idle with junk on the bus.
    task automatic send_cmd(input in_t cmd);
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid       <= 1'b0;
            s_data.mode   <= MODE_W'($urandom);
            s_data.amount <= $urandom;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    initial begin
        int ph;
        int n;
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queue, zero and full thresholds, unused mode, exact-age boundary
        send_cmd(make_cmd(MODE_EXPIRE, '0));
        send_cmd(make_cmd(MODE_EXPIRE, AMOUNT_MAX));
        send_cmd(make_cmd(MODE_INSERT, AMOUNT_MAX));
        send_cmd(make_cmd(MODE_SPARE, AMOUNT_MAX));
        send_cmd(make_cmd(MODE_EXPIRE, 32'd1));
        send_cmd(make_cmd(MODE_EXPIRE, '0));
        send_cmd(make_cmd(MODE_INSERT, '0));
        send_cmd(make_cmd(MODE_ADVANCE, AMOUNT_MAX));
        send_cmd(make_cmd(MODE_INSERT, 32'h5555_5555));
        send_cmd(make_cmd(MODE_EXPIRE, AMOUNT_MAX));
        send_cmd(make_cmd(MODE_ADVANCE, '0));
        send_cmd(make_cmd(MODE_ADVANCE, 32'd1));
        send_cmd(make_cmd(MODE_INSERT, 32'hAAAA_AAAA));
        send_cmd(make_cmd(MODE_EXPIRE, 32'd2));
        send_cmd(make_cmd(MODE_EXPIRE, 32'd1));
        send_cmd(make_cmd(MODE_SPARE, '0));
        send_cmd(make_cmd(MODE_ADVANCE, 32'h5555_5555));
        send_cmd(make_cmd(MODE_ADVANCE, 32'hAAAA_AAAA));
        send_cmd(make_cmd(MODE_EXPIRE, '0));

        // random traffic: no idling, sender idle, receiver stalls, both
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 33 : 0;
            recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 33 : 0;
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (ph == 0 && n == 40) begin
                    hold_left = HOLD_CYCLES;
                end
                send_cmd(random_cmd());
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (20) @(posedge aclk);

        $display("summary: %0d commands checked, %0d stamps expired, %0d inserts refused",
                 cmd_total, stamps_expired, inserts_refused);
        $display("summary: peak occupancy %0d, time saturated %0b, %0d mismatches",
                 peak_fill, hit_time_ceiling, mismatches);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/taeq_pkg.sv
src/taeq_ctrl.sv
src/taeq_dp.sv
src/timestamp_age_expiry_queue.sv
src/taeq_checker.sv
sim/taeq_checker.sv
sim/tb.sv
